// ===== rtl/core/tti_pkg.sv =====
// Shared types, codes and character helpers for the text-to-integer parser.
// No dependencies; used by every module under rtl/core.
package tti_pkg;

  // Accumulator width; digits wrap modulo 2^ACC_BITS.
  localparam int ACC_BITS = 64;
  localparam int VALUE_BITS = 64;

  localparam logic [4:0] BASE_DEFAULT = 5'd10;
  localparam logic [4:0] BASE_HEX = 5'd16;

  // Configuration register indexes
  localparam logic [1:0] REG_NUMBER_BASE = 2'd0;
  localparam logic [1:0] REG_SIGNED_MODE = 2'd1;
  localparam logic [1:0] REG_RESULT_WIDTH = 2'd2;

  // Result width codes
  localparam logic [1:0] RW_8 = 2'd0;
  localparam logic [1:0] RW_16 = 2'd1;
  localparam logic [1:0] RW_32 = 2'd2;
  localparam logic [1:0] RW_64 = 2'd3;

  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [4:0] NOT_A_DIGIT = 5'd16;

  typedef enum logic [2:0] {
    PH_LEAD  = 3'd0,
    PH_SIGN  = 3'd1,
    PH_DIGIT = 3'd2,
    PH_TRAIL = 3'd3,
    PH_BAD   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_INVALID = 2'd1,
    ERR_RANGE   = 2'd2
  } err_t;

  typedef struct packed {
    logic [4:0] number_base;
    logic       signed_mode;
    logic [1:0] result_width;
  } cfg_t;

  typedef struct packed {
    phase_t              phase;
    logic [ACC_BITS-1:0] acc;
    logic                negative;
    logic                prefix_ok;
  } parse_state_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // Hex digit value, NOT_A_DIGIT for any other byte.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = NOT_A_DIGIT;
    if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
    return v;
  endfunction

endpackage

// ===== rtl/core/text_to_integer_parser.sv =====
// Top level of the text-to-integer parser: input register, parse state, result register.
// Depends on tti_pkg, tti_scan and tti_finish.
//
// Feed one character per request; the request with end_of_text set returns the value and
// a status (ok, invalid text, out of range) as a single result, then the parser restarts.
// Other characters produce no result. One character is taken every cycle while the input is
// not stalled; the result is registered in the result register, where it is held until taken.
// Input is stalled only when a terminator waits behind an untaken result. Configuration
// writes (base, signed mode, result width) are always accepted; write them between texts.
module text_to_integer_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_char_code,
  input  logic                           in_end_of_text,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tti_pkg::VALUE_BITS-1:0] out_parsed_value,
  output logic [1:0]                     out_error_code,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [7:0]                     cfg_data
);

  tti_pkg::cfg_t         cfg_r;
  tti_pkg::parse_state_t state_r;
  tti_pkg::parse_state_t state_nxt;

  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_eot_r;
  logic       s1_go;

  logic                           out_valid_r;
  logic [tti_pkg::VALUE_BITS-1:0] out_value_r;
  tti_pkg::err_t                  out_err_r;
  logic [tti_pkg::VALUE_BITS-1:0] fin_value;
  tti_pkg::err_t                  fin_err;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.number_base <= tti_pkg::BASE_DEFAULT;
      cfg_r.signed_mode <= 1'b0;
      cfg_r.result_width <= tti_pkg::RW_64;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tti_pkg::REG_NUMBER_BASE:  cfg_r.number_base <= cfg_data[4:0];
        tti_pkg::REG_SIGNED_MODE:  cfg_r.signed_mode <= cfg_data[0];
        tti_pkg::REG_RESULT_WIDTH: cfg_r.result_width <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // A terminator may only advance when the result slot frees up.
  assign s1_go = s1_valid_r && (!s1_eot_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_char_r <= in_char_code;
      s1_eot_r <= in_end_of_text;
    end
  end

  tti_scan u_scan (
    .char_code   (s1_char_r),
    .end_of_text (s1_eot_r),
    .cfg         (cfg_r),
    .cur         (state_r),
    .nxt         (state_nxt)
  );

  tti_finish u_finish (
    .cfg   (cfg_r),
    .cur   (state_r),
    .value (fin_value),
    .err   (fin_err)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase <= tti_pkg::PH_LEAD;
      state_r.acc <= '0;
      state_r.negative <= 1'b0;
      state_r.prefix_ok <= 1'b0;
    end else if (s1_go) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_eot_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_eot_r) begin
      out_value_r <= fin_value;
      out_err_r <= fin_err;
    end
  end

  assign out_valid = out_valid_r;
  assign out_parsed_value = out_value_r;
  assign out_error_code = out_err_r;

endmodule

// ===== rtl/core/tti_scan.sv =====
// Per-character next-state logic: phase, digit accumulation, sign and 0x prefix.
// Depends on tti_pkg.
module tti_scan (
  input  logic [7:0]            char_code,
  input  logic                  end_of_text,
  input  tti_pkg::cfg_t         cfg,
  input  tti_pkg::parse_state_t cur,
  output tti_pkg::parse_state_t nxt
);

  logic [4:0]                   base;
  logic [4:0]                   dval;
  logic                         digit;
  logic                         blank;
  logic [tti_pkg::ACC_BITS-1:0] acc_step;

  assign base = (cfg.number_base == 5'd0) ? tti_pkg::BASE_DEFAULT : cfg.number_base;
  assign dval = tti_pkg::hex_value(char_code);
  assign digit = dval < base;
  assign blank = tti_pkg::is_blank(char_code);
  assign acc_step = cur.acc * tti_pkg::ACC_BITS'(base) + tti_pkg::ACC_BITS'(dval);

  always_comb begin
    nxt = cur;
    if (end_of_text) begin
      // restart for the next text
      nxt.phase = tti_pkg::PH_LEAD;
      nxt.acc = '0;
      nxt.negative = 1'b0;
      nxt.prefix_ok = 1'b0;
    end else begin
      case (cur.phase)
        tti_pkg::PH_LEAD, tti_pkg::PH_SIGN: begin
          if (!blank) begin
            if (cur.phase == tti_pkg::PH_LEAD && cfg.signed_mode &&
                char_code == tti_pkg::CH_MINUS) begin
              nxt.negative = 1'b1;
              nxt.phase = tti_pkg::PH_SIGN;
            end else if (digit) begin
              nxt.acc = acc_step;
              nxt.prefix_ok = (base == tti_pkg::BASE_HEX) && (char_code == tti_pkg::CH_ZERO);
              nxt.phase = tti_pkg::PH_DIGIT;
            end else begin
              nxt.phase = tti_pkg::PH_BAD;
            end
          end
        end
        tti_pkg::PH_DIGIT: begin
          nxt.prefix_ok = 1'b0;
          if (cur.prefix_ok && (char_code == tti_pkg::CH_LOWER_X ||
                                char_code == tti_pkg::CH_UPPER_X)) begin
            nxt.phase = tti_pkg::PH_DIGIT;
          end else if (digit) begin
            nxt.acc = acc_step;
          end else if (blank) begin
            nxt.phase = tti_pkg::PH_TRAIL;
          end else begin
            nxt.phase = tti_pkg::PH_BAD;
          end
        end
        tti_pkg::PH_TRAIL: nxt.phase = tti_pkg::PH_TRAIL;
        default: nxt.phase = tti_pkg::PH_BAD;
      endcase
    end
  end

endmodule

// ===== rtl/core/tti_finish.sv =====
// Terminator logic: apply the sign, range-check against the selected width, set status.
// Depends on tti_pkg.
module tti_finish (
  input  tti_pkg::cfg_t                  cfg,
  input  tti_pkg::parse_state_t          cur,
  output logic [tti_pkg::VALUE_BITS-1:0] value,
  output tti_pkg::err_t                  err
);

  logic [tti_pkg::VALUE_BITS-1:0] mag;
  logic [tti_pkg::VALUE_BITS-1:0] val;
  logic                           fits;

  assign mag = tti_pkg::VALUE_BITS'(cur.acc);
  assign val = cur.negative ? (~mag + tti_pkg::VALUE_BITS'(1)) : mag;

  // In range when the bits above the width are all zero (unsigned) or all
  // copies of the sign bit (signed).
  always_comb begin
    unique case (cfg.result_width)
      tti_pkg::RW_8:  fits = cfg.signed_mode ? (&val[63:7] || ~|val[63:7]) : ~|val[63:8];
      tti_pkg::RW_16: fits = cfg.signed_mode ? (&val[63:15] || ~|val[63:15]) : ~|val[63:16];
      tti_pkg::RW_32: fits = cfg.signed_mode ? (&val[63:31] || ~|val[63:31]) : ~|val[63:32];
      tti_pkg::RW_64: fits = 1'b1;
    endcase
  end

  always_comb begin
    value = '0;
    if (cur.phase == tti_pkg::PH_DIGIT || cur.phase == tti_pkg::PH_TRAIL) begin
      if (fits) begin
        err = tti_pkg::ERR_OK;
        value = val;
      end else begin
        err = tti_pkg::ERR_RANGE;
      end
    end else begin
      err = tti_pkg::ERR_INVALID;
    end
  end

endmodule

// ===== tb/tti_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for text_to_integer_parser: follows the request, result and register channels,
// tracks its own parse state and register copy, and checks every result. Needs tti_pkg.
module tti_checker
  import tti_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [7:0]            in_char_code,
  input  logic                  in_end_of_text,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [VALUE_BITS-1:0] out_parsed_value,
  input  logic [1:0]            out_error_code,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_data,
  output int                    errors,
  output int                    pending
);

  typedef struct {
    logic [VALUE_BITS-1:0] value;
    err_t                  status;
  } verdict_t;

  verdict_t            verdicts_q[$];
  cfg_t                regs;
  phase_t              phase;
  logic [ACC_BITS-1:0] acc;
  logic                neg;
  logic                pfx;

  initial begin
    errors = 0;
    pending = 0;
  end

  task automatic report(input string msg);
    if (errors < 40) $display("%0t mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic logic blank_byte(input logic [7:0] c);
    return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // Value of a hex digit in either case, 16 for anything else.
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h61 + 8'd10);
    if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41 + 8'd10);
    return 5'd16;
  endfunction

  task automatic restart_text();
    phase = PH_LEAD;
    acc = '0;
    neg = 1'b0;
    pfx = 1'b0;
  endtask

  task automatic parse_char(input logic [7:0] c, input logic eot);
    logic [4:0]            radix;
    logic [4:0]            v;
    logic                  digit;
    logic [VALUE_BITS-1:0] val;
    logic [VALUE_BITS-1:0] span;
    logic [VALUE_BITS-1:0] half;
    err_t                  status;
    int                    bits;
    radix = (regs.number_base == 5'd0) ? BASE_DEFAULT : regs.number_base;
    v = digit_value(c);
    digit = v < radix;
    if (eot) begin
      val = '0;
      status = ERR_OK;
      if (phase == PH_DIGIT || phase == PH_TRAIL) begin
        val = neg ? ({VALUE_BITS{1'b0}} - acc) : acc;
        if (regs.result_width != RW_64) begin
          bits = 8 << regs.result_width;
          span = (64'd1 << bits) - 64'd1;
          half = 64'd1 << (bits - 1);
          if (regs.signed_mode ? (val + half > span) : (val > span)) status = ERR_RANGE;
        end
        if (status != ERR_OK) val = '0;
      end else begin
        status = ERR_INVALID;
      end
      verdicts_q.push_back('{val, status});
      restart_text();
    end else begin
      case (phase)
        PH_LEAD, PH_SIGN: begin
          if (!blank_byte(c)) begin
            if (phase == PH_LEAD && regs.signed_mode && c == CH_MINUS) begin
              neg = 1'b1;
              phase = PH_SIGN;
            end else if (digit) begin
              acc = acc * ACC_BITS'(radix) + ACC_BITS'(v);
              pfx = radix == BASE_HEX && c == CH_ZERO;
              phase = PH_DIGIT;
            end else begin
              phase = PH_BAD;
            end
          end
        end
        PH_DIGIT: begin
          // An x right after a leading zero in base 16 is the prefix: drop it
          if (pfx && (c == CH_LOWER_X || c == CH_UPPER_X)) begin
          end else if (digit) begin
            acc = acc * ACC_BITS'(radix) + ACC_BITS'(v);
          end else if (blank_byte(c)) begin
            phase = PH_TRAIL;
          end else begin
            phase = PH_BAD;
          end
          pfx = 1'b0;
        end
        PH_TRAIL: begin
        end
        default: phase = PH_BAD;
      endcase
    end
  endtask

  always @(posedge clk) begin
    verdict_t w;
    if (!rst_n) begin
      regs = '{number_base: BASE_DEFAULT, signed_mode: 1'b0, result_width: RW_64};
      restart_text();
      verdicts_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (verdicts_q.size() == 0) begin
          report($sformatf("unexpected result value %h status %0d",
                           out_parsed_value, out_error_code));
        end else begin
          w = verdicts_q.pop_front();
          if (out_parsed_value !== w.value)
            report($sformatf("value %h, predicted %h", out_parsed_value, w.value));
          if (out_error_code !== w.status)
            report($sformatf("status %0d, predicted %0d", out_error_code, w.status));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NUMBER_BASE:  regs.number_base = cfg_data[4:0];
          REG_SIGNED_MODE:  regs.signed_mode = cfg_data[0];
          REG_RESULT_WIDTH: regs.result_width = cfg_data[1:0];
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready) parse_char(in_char_code, in_end_of_text);
    end
    pending = verdicts_q.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Top of the parser testbench: drives boundary texts and then random texts under changing
// radix, sign and width settings, and gives the verdict. Needs tti_pkg and tti_checker.
module tb;
  import tti_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int LIMIT_NS = 2_000_000;
  localparam int RANDOM_CHARS = 200;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_char_code = 8'h00;
  logic                  in_end_of_text = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [VALUE_BITS-1:0] out_parsed_value;
  logic [1:0]            out_error_code;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_index = 2'd0;
  logic [7:0]            cfg_data = 8'h00;
  int                    errors;
  int                    pending;

  int         src_gap_max = 0;
  int         sink_gap_max = 0;
  int         stall_len = 0;
  int         chars_sent = 0;
  logic [4:0] cur_base = BASE_DEFAULT;
  logic       cur_signed = 1'b0;

  text_to_integer_parser dut (.*);
  tti_checker chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("[text_to_integer_parser] ERROR");
    $finish;
  end

  // Result side: random hold-off per result, or one long stall when asked for.
  initial begin : sink
    int w;
    wait (rst_n === 1'b1);
    forever begin
      w = (stall_len != 0) ? stall_len : $urandom_range(0, sink_gap_max);
      stall_len = 0;
      if (w > 0) begin
        out_ready = 1'b0;
        repeat (w) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Valid stays high after a request is taken; the next request or a pause decides.
  task automatic send_char(input logic [7:0] c, input logic eot);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_char_code = c;
    in_end_of_text = eot;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
    send_char(8'($urandom), 1'b1);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Unused register bits carry random data; the block must ignore them.
  task automatic configure(input logic [4:0] base, input logic sgn, input logic [1:0] rw);
    settle();
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, 8'($urandom));
    write_reg(REG_NUMBER_BASE, {3'($urandom), base});
    write_reg(REG_SIGNED_MODE, {7'($urandom), sgn});
    write_reg(REG_RESULT_WIDTH, {6'($urandom), rw});
    cfg_valid = 1'b0;
    cur_base = base;
    cur_signed = sgn;
  endtask

  function automatic logic [7:0] pick_blank();
    return ($urandom_range(0, 5) == 0) ? CH_SPACE : 8'($urandom_range(9, 13));
  endfunction

  function automatic logic [7:0] hex_char(input int v);
    if (v < 10) return 8'(CH_ZERO + v);
    return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 10);
  endfunction

  function automatic int gap_limit();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 10;
    endcase
  endfunction

  // Mostly well-formed numbers with random content; some raw noise and broken tails.
  task automatic send_random_text();
    int radix;
    int top;
    int n;
    int shape;
    radix = (cur_base == 5'd0) ? 10 : int'(cur_base);
    top = (radix > 16) ? 15 : radix - 1;
    shape = $urandom_range(0, 9);
    if (shape == 0) begin
      repeat ($urandom_range(0, 6)) send_char(8'($urandom), 1'b0);
    end else begin
      repeat ($urandom_range(0, 2)) send_char(pick_blank(), 1'b0);
      if ($urandom_range(0, 3) == 0 && (cur_signed || $urandom_range(0, 3) == 0)) begin
        send_char(CH_MINUS, 1'b0);
        repeat ($urandom_range(0, 1)) send_char(pick_blank(), 1'b0);
      end
      if (radix == 16 && $urandom_range(0, 1)) begin
        send_char(CH_ZERO, 1'b0);
        send_char($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X, 1'b0);
      end
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 22) : $urandom_range(1, 6);
      repeat (n)
        send_char(hex_char(($urandom_range(0, 3) == 0) ? top : $urandom_range(0, top)), 1'b0);
      if (shape == 1) send_char(8'($urandom), 1'b0);
      if ($urandom_range(0, 2) == 0) begin
        send_char(pick_blank(), 1'b0);
        repeat ($urandom_range(0, 3)) send_char(8'($urandom), 1'b0);
      end
    end
    send_char(8'($urandom), 1'b1);
  endtask

  initial begin : stimulus
    int start;
    int p;
    logic [4:0] base;
    logic [1:0] rw;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: base ten, unsigned, no range check
    src_gap_max = 3;
    sink_gap_max = 3;
    send_text("");
    send_text(" \t\n\013\f\0157");
    send_text("18446744073709551615");
    send_text("18446744073709551616");
    send_text("12x");
    send_text("42 \001z9");
    send_text("-5");

    configure(5'd10, 1'b1, RW_8);
    send_text("127");
    send_text("128");
    send_text("-128");
    send_text("-129");
    send_text("- \t7");
    send_text("-");
    send_text("--1");

    configure(5'd10, 1'b0, RW_8);
    send_text("255");
    send_text("256");

    configure(BASE_HEX, 1'b0, RW_16);
    send_text("0xFFFF");
    send_text("0x");
    send_text("0X10000");
    send_text("x1");
    send_text("0xx");

    configure(BASE_HEX, 1'b1, RW_32);
    send_text("-0x80000000");
    send_text("0x7fffffff");
    send_text("0x80000000");
    send_text("-0X");

    configure(5'd1, 1'b0, RW_64);
    send_text("000");
    send_text("01");

    configure(5'd31, 1'b1, RW_16);
    send_text("fF");

    configure(5'd0, 1'b1, RW_32);
    send_text("-2147483649");
    send_text("2147483647");

    configure(5'd2, 1'b1, RW_64);
    send_text("-1 x");

    // Random texts, one register setting per phase; the first phases take the extremes
    start = chars_sent;
    p = 0;
    while (chars_sent - start < RANDOM_CHARS) begin
      case (p)
        0: configure(BASE_HEX, 1'b1, RW_8);
        1: configure(5'd1, 1'b0, RW_64);
        2: configure(5'd10, 1'b0, RW_8);
        3: configure(5'd31, 1'b1, RW_32);
        4: configure(5'd0, 1'b0, RW_16);
        5: configure(5'd2, 1'b1, RW_64);
        6: configure(BASE_HEX, 1'b0, RW_32);
        default: begin
          base = ($urandom_range(0, 2) == 0) ? 5'($urandom_range(0, 31))
                 : ($urandom_range(0, 1) ? 5'd10 : BASE_HEX);
          rw = 2'($urandom_range(0, 3));
          configure(base, 1'($urandom_range(0, 1)), rw);
        end
      endcase
      src_gap_max = gap_limit();
      sink_gap_max = gap_limit();
      // Hold the result side off while requests keep coming, so the input backs up
      if (p == 0) begin
        src_gap_max = 0;
        stall_len = 80;
      end
      repeat (8) send_random_text();
      p++;
    end

    settle();
    repeat (6) @(negedge clk);
    if (errors == 0) begin
      $display("[text_to_integer_parser] OK");
    end else begin
      $display("[text_to_integer_parser] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tti_pkg.sv
rtl/core/tti_scan.sv
rtl/core/tti_finish.sv
rtl/core/text_to_integer_parser.sv
tb/tti_checker.sv
tb/tb.sv
